// ----- hdl/tlbpat_pkg.sv -----
package tlbpat_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_COUNT  = 256;

    localparam int ADDR_W    = 16;
    localparam int VPAGE_W   = 8;
    localparam int OFFSET_W  = 8;
    localparam int FRAME_W   = 8;
    localparam int NFF_W     = 9;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 32;

    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);

    localparam logic [OUTCOME_W-1:0] OUTCOME_TLB_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_TABLE_HIT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FAULT     = 2'd2;

    localparam logic [NFF_W-1:0]   NFF_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic   hit;
        frame_t frame;
    } tlb_lookup_t;

    typedef struct packed {
        logic   present;
        frame_t frame;
    } pt_resp_t;

    // virtual page modulo PAGE_COUNT; quotient is below 16 as PAGE_COUNT >= 16
    function automatic page_t reduce_page(input logic [VPAGE_W-1:0] vpage);
        logic [11:0] r;
        r = {4'b0, vpage};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= 12'(PAGE_COUNT << k))
            begin
                r = r - 12'(PAGE_COUNT << k);
            end
        end
        return r[PAGE_W-1:0];
    endfunction

endpackage

// ----- hdl/tlbpat_req_if.sv -----
interface tlbpat_req_if;
    import tlbpat_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] vaddr;

    modport source (output valid, output vaddr, input ready);
    modport sink (input valid, input vaddr, output ready);
endinterface

// ----- hdl/tlbpat_rsp_if.sv -----
interface tlbpat_rsp_if;
    import tlbpat_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    paddr;
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   tlb_hit_total;
    logic [COUNT_W-1:0]   table_hit_total;

    modport source (output valid, output paddr, output outcome,
                    output tlb_hit_total, output table_hit_total, input ready);
    modport sink (input valid, input paddr, input outcome,
                  input tlb_hit_total, input table_hit_total, output ready);
endinterface

// ----- hdl/tlbpat_ram.sv -----
module tlbpat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tlbpat_tlb.sv -----
module tlbpat_tlb (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlbpat_pkg::page_t     page,
    input  logic                  refill,
    input  tlbpat_pkg::frame_t    refill_frame,
    output tlbpat_pkg::tlb_lookup_t lookup
);
    import tlbpat_pkg::*;

    logic                 valid_reg [TLB_ENTRIES];
    page_t                tag_reg   [TLB_ENTRIES];
    frame_t               frame_reg [TLB_ENTRIES];
    logic [TLB_IDX_W-1:0] slot_reg;
    logic [TLB_IDX_W-1:0] slot_next;

    // descending scan so the lowest matching slot wins
    always_comb
    begin
        lookup.hit   = 1'b0;
        lookup.frame = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (valid_reg[k] && (tag_reg[k] == page))
            begin
                lookup.hit   = 1'b1;
                lookup.frame = frame_reg[k];
            end
        end
    end

    assign slot_next = (slot_reg == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                valid_reg[k] <= 1'b0;
                tag_reg[k]   <= '0;
                frame_reg[k] <= '0;
            end
        end
        else if (refill)
        begin
            valid_reg[slot_reg] <= 1'b1;
            tag_reg[slot_reg]   <= page;
            frame_reg[slot_reg] <= refill_frame;
            slot_reg            <= slot_next;
        end
    end

endmodule

// ----- hdl/tlbpat_page_table.sv -----
module tlbpat_page_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlbpat_pkg::page_t    rd_page,
    input  tlbpat_pkg::page_t    page,
    input  logic                 miss,
    output tlbpat_pkg::pt_resp_t resp
);
    import tlbpat_pkg::*;

    logic [PAGE_COUNT-1:0] present_reg;
    logic [NFF_W-1:0]      nff_reg;
    logic                  byp_reg;
    frame_t                byp_data_reg;
    frame_t                ram_q;
    frame_t                new_frame;
    logic                  alloc;

    assign new_frame = nff_reg[FRAME_W-1:0];
    assign alloc     = miss && !present_reg[page];

    tlbpat_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(PAGE_COUNT)
    ) u_frames (
        .clk  (clk),
        .we   (alloc),
        .waddr(page),
        .wdata(new_frame),
        .raddr(rd_page),
        .rdata(ram_q)
    );

    assign resp.present = present_reg[page];
    assign resp.frame   = !present_reg[page] ? new_frame :
                          byp_reg            ? byp_data_reg : ram_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            nff_reg     <= '0;
            byp_reg     <= 1'b0;
        end
        else
        begin
            // frame written at the same edge as the read: forward it
            byp_reg <= alloc && (page == rd_page);
            if (alloc)
            begin
                present_reg[page] <= 1'b1;
                if (nff_reg != NFF_MAX)
                begin
                    nff_reg <= nff_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= new_frame;
    end

endmodule

// ----- hdl/tlb_page_address_translation_unit.sv -----
// Paged address translation with a 16-entry fully associative TLB.
//
// request  (sink):   one 16-bit logical address per transaction; page in
//                    bits 15..8, offset in bits 7..0.
// response (source): physical address, outcome (TLB hit, page table hit or
//                    fault with a newly assigned frame) and saturating
//                    running counts of TLB hits and page table hits.
//
// Throughput is one transaction per cycle unless the receiver stalls. The
// page table RAM is read as a request enters the input register; lookup,
// allocation and TLB refill happen as it moves to the output register.
// A response held by a stalled receiver sits in the output register while
// one more request waits in the input register; request.ready drops only
// when both are full.
// Reset clears the TLB, the page present bits, the free-frame pointer, the
// refill pointer and both counts; no clearing pass is needed afterwards.
module tlb_page_address_translation_unit (
    input logic          clk,
    input logic          rst_n,
    tlbpat_req_if.sink   request,
    tlbpat_rsp_if.source response
);
    import tlbpat_pkg::*;

    logic                  s1_valid_reg;
    page_t                 s1_page_reg;
    logic [OFFSET_W-1:0]   s1_offset_reg;

    logic                  out_valid_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [OUTCOME_W-1:0]  out_outcome_reg;

    logic [COUNT_W-1:0]    tlb_cnt_reg;
    logic [COUNT_W-1:0]    tlb_cnt_next;
    logic [COUNT_W-1:0]    table_cnt_reg;
    logic [COUNT_W-1:0]    table_cnt_next;

    logic                  fire;
    logic                  accept;
    logic                  miss;
    page_t                 in_page;
    page_t                 rd_page;
    tlb_lookup_t           tlb_res;
    pt_resp_t              pt_res;
    frame_t                frame;
    logic [OUTCOME_W-1:0]  outcome;

    assign fire          = s1_valid_reg && (!out_valid_reg || response.ready);
    assign request.ready = !s1_valid_reg || fire;
    assign accept        = request.valid && request.ready;

    assign in_page = reduce_page(request.vaddr[ADDR_W-1:OFFSET_W]);
    assign rd_page = accept ? in_page : s1_page_reg;

    assign miss = fire && !tlb_res.hit;

    tlbpat_tlb u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .page        (s1_page_reg),
        .refill      (miss),
        .refill_frame(pt_res.frame),
        .lookup      (tlb_res)
    );

    tlbpat_page_table u_pt (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_page(rd_page),
        .page   (s1_page_reg),
        .miss   (miss),
        .resp   (pt_res)
    );

    always_comb
    begin
        tlb_cnt_next   = tlb_cnt_reg;
        table_cnt_next = table_cnt_reg;
        if (tlb_res.hit)
        begin
            frame   = tlb_res.frame;
            outcome = OUTCOME_TLB_HIT;
            if (tlb_cnt_reg != COUNT_MAX)
            begin
                tlb_cnt_next = tlb_cnt_reg + 1'b1;
            end
        end
        else if (pt_res.present)
        begin
            frame   = pt_res.frame;
            outcome = OUTCOME_TABLE_HIT;
            if (table_cnt_reg != COUNT_MAX)
            begin
                table_cnt_next = table_cnt_reg + 1'b1;
            end
        end
        else
        begin
            frame   = pt_res.frame;
            outcome = OUTCOME_FAULT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tlb_cnt_reg   <= '0;
            table_cnt_reg <= '0;
        end
        else
        begin
            if (request.ready)
            begin
                s1_valid_reg <= request.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                tlb_cnt_reg   <= tlb_cnt_next;
                table_cnt_reg <= table_cnt_next;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_page_reg   <= in_page;
            s1_offset_reg <= request.vaddr[OFFSET_W-1:0];
        end
        if (fire)
        begin
            out_addr_reg    <= {frame, s1_offset_reg};
            out_outcome_reg <= outcome;
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.paddr           = out_addr_reg;
    assign response.outcome         = out_outcome_reg;
    assign response.tlb_hit_total   = tlb_cnt_reg;
    assign response.table_hit_total = table_cnt_reg;

endmodule

// ----- hdl/tlbpat_checker.sv -----
module tlbpat_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [tlbpat_pkg::ADDR_W-1:0]    paddr,
    input logic [tlbpat_pkg::OUTCOME_W-1:0] outcome,
    input logic [tlbpat_pkg::COUNT_W-1:0]   tlb_hit_total,
    input logic [tlbpat_pkg::COUNT_W-1:0]   table_hit_total
);
    import tlbpat_pkg::*;

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (outcome == OUTCOME_TLB_HIT || outcome == OUTCOME_TABLE_HIT ||
                       outcome == OUTCOME_FAULT))
        else $error("response outcome code out of range");

    a_tlb_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && outcome == OUTCOME_TLB_HIT) |-> (tlb_hit_total != '0))
        else $error("TLB hit reported with zero TLB hit count");

    a_table_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && outcome == OUTCOME_TABLE_HIT) |-> (table_hit_total != '0))
        else $error("page table hit reported with zero table hit count");

    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response appeared without a preceding request transaction");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(paddr) && $stable(outcome)))
        else $error("stalled response changed");

endmodule

bind tlb_page_address_translation_unit tlbpat_checker u_tlbpat_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .rsp_valid       (response.valid),
    .rsp_ready       (response.ready),
    .paddr           (response.paddr),
    .outcome         (response.outcome),
    .tlb_hit_total   (response.tlb_hit_total),
    .table_hit_total (response.table_hit_total)
);
